// ----- sv/vpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_pkg
// Shared constants, micro-operation codes and controller/datapath types of
// the video port command and DMA block.
// ----------------------------------------------------------------------------
package vpc_pkg;

    localparam int VRAM_BYTES_DEF  = 65536;
    localparam int CRAM_BYTES_DEF  = 128;
    localparam int VSRAM_BYTES_DEF = 128;
    localparam int REG_COUNT_DEF   = 32;

    // Register numbers used by the datapath
    localparam logic [4:0] REG_MODE2    = 5'd1;
    localparam logic [4:0] REG_AUTOINC  = 5'd15;
    localparam logic [4:0] REG_LEN_LO   = 5'd19;
    localparam logic [4:0] REG_LEN_HI   = 5'd20;
    localparam logic [4:0] REG_SRC_LO   = 5'd21;
    localparam logic [4:0] REG_SRC_HI   = 5'd22;
    localparam logic [4:0] REG_DMA_KIND = 5'd23;

    // Access mode codes
    localparam logic [5:0] MODE_VRAM_WR  = 6'h04;
    localparam logic [5:0] MODE_CRAM_WR  = 6'h0C;
    localparam logic [5:0] MODE_VSRAM_WR = 6'h14;
    localparam logic [5:0] MODE_VRAM_RD  = 6'h00;
    localparam logic [5:0] MODE_CRAM_RD  = 6'h20;
    localparam logic [5:0] MODE_VSRAM_RD = 6'h10;

    // DMA kinds (register 0x17 bits 7..6)
    localparam logic [1:0] DMA_FILL = 2'd2;
    localparam logic [1:0] DMA_COPY = 2'd3;

    // Input actions
    localparam logic [1:0] ACT_CTRL    = 2'd0;
    localparam logic [1:0] ACT_WR      = 2'd1;
    localparam logic [1:0] ACT_RD_WORD = 2'd2;
    localparam logic [1:0] ACT_RD_BYTE = 2'd3;

    // Datapath micro-operations
    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CLEAR   = 4'd1;
    localparam logic [3:0] OP_ACCEPT  = 4'd2;
    localparam logic [3:0] OP_CTRL    = 4'd3;
    localparam logic [3:0] OP_WR_LO   = 4'd4;
    localparam logic [3:0] OP_WR_HI   = 4'd5;
    localparam logic [3:0] OP_FILL    = 4'd6;
    localparam logic [3:0] OP_RD_LO   = 4'd7;
    localparam logic [3:0] OP_RD_MID  = 4'd8;
    localparam logic [3:0] OP_RD_HI   = 4'd9;
    localparam logic [3:0] OP_RD_BYTE = 4'd10;
    localparam logic [3:0] OP_CP_RD   = 4'd11;
    localparam logic [3:0] OP_CP_WR   = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       copy_go;
        logic       fill_go;
        logic       cnt_last;
        logic       clr_last;
    } t_status;

endpackage

// ----- sv/video_port_command_and_dma.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_port_command_and_dma
// Control and data ports of a tile video chip with VRAM fill and copy.
// ----------------------------------------------------------------------------
// Usage: present i_action and i_data_word with start; the transfer is taken
// at an edge where start is high and busy is low. Exactly one result per
// transfer appears on o_read_data, o_irq_recheck and o_dirty_flags for one
// cycle with o_result_valid; the receiver cannot stall it.
// After accept: control word S_CTRL; data write S_WR_LO, S_WR_HI; word read
// S_RD_LO, S_RD_MID, S_RD_HI; byte read S_RD_LO, S_RD_BYTE; then S_DONE
// strobes and busy drops in the cycle after; no new transfer is taken
// until then. A copy adds S_CP_RD, S_CP_WR per byte (read then write on the
// single VRAM port), up to 65536 bytes; a fill adds S_FILL per byte. After
// reset the block sweeps every memory to zero, one address a cycle over the
// VRAM range with busy held high; registers and command state clear at once.
// ----------------------------------------------------------------------------
module video_port_command_and_dma #(
    parameter int VRAM_BYTES  = vpc_pkg::VRAM_BYTES_DEF,
    parameter int CRAM_BYTES  = vpc_pkg::CRAM_BYTES_DEF,
    parameter int VSRAM_BYTES = vpc_pkg::VSRAM_BYTES_DEF,
    parameter int REG_COUNT   = vpc_pkg::REG_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_action,
    input  logic [15:0] i_data_word,
    output logic        o_result_valid,
    output logic [15:0] o_read_data,
    output logic        o_irq_recheck,
    output logic [3:0]  o_dirty_flags
);

    vpc_pkg::t_cmd    cmd;
    vpc_pkg::t_status status;

    vpc_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .i_action       (i_action),
        .i_status       (status),
        .o_cmd          (cmd),
        .busy           (busy),
        .o_result_valid (o_result_valid)
    );

    vpc_dp #(
        .VRAM_BYTES  (VRAM_BYTES),
        .CRAM_BYTES  (CRAM_BYTES),
        .VSRAM_BYTES (VSRAM_BYTES),
        .REG_COUNT   (REG_COUNT)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_action      (i_action),
        .i_data_word   (i_data_word),
        .o_status      (status),
        .o_read_data   (o_read_data),
        .o_irq_recheck (o_irq_recheck),
        .o_dirty_flags (o_dirty_flags)
    );

endmodule

// ----- sv/vpc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module vpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/vpc_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_ctrl
// Sequencer: clears memories after reset, then steps each transfer through
// the datapath micro-operations and strobes the result.
// ----------------------------------------------------------------------------
module vpc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  logic [1:0]      i_action,
    input  vpc_pkg::t_status i_status,
    output vpc_pkg::t_cmd   o_cmd,
    output logic            busy,
    output logic            o_result_valid
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_CTRL    = 4'd2;
    localparam logic [3:0] S_WR_LO   = 4'd3;
    localparam logic [3:0] S_WR_HI   = 4'd4;
    localparam logic [3:0] S_FILL    = 4'd5;
    localparam logic [3:0] S_RD_LO   = 4'd6;
    localparam logic [3:0] S_RD_MID  = 4'd7;
    localparam logic [3:0] S_RD_HI   = 4'd8;
    localparam logic [3:0] S_RD_BYTE = 4'd9;
    localparam logic [3:0] S_CP_RD   = 4'd10;
    localparam logic [3:0] S_CP_WR   = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state  = r_state;
        o_cmd.op = vpc_pkg::OP_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd.op = vpc_pkg::OP_CLEAR;
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.op = vpc_pkg::OP_ACCEPT;
                    case (i_action)
                        vpc_pkg::ACT_CTRL: n_state = S_CTRL;
                        vpc_pkg::ACT_WR:   n_state = S_WR_LO;
                        default:           n_state = S_RD_LO;
                    endcase
                end
            end
            S_CTRL: begin
                o_cmd.op = vpc_pkg::OP_CTRL;
                n_state  = i_status.copy_go ? S_CP_RD : S_DONE;
            end
            S_WR_LO: begin
                o_cmd.op = vpc_pkg::OP_WR_LO;
                n_state  = S_WR_HI;
            end
            S_WR_HI: begin
                o_cmd.op = vpc_pkg::OP_WR_HI;
                n_state  = i_status.fill_go ? S_FILL : S_DONE;
            end
            S_FILL: begin
                o_cmd.op = vpc_pkg::OP_FILL;
                if (i_status.cnt_last) begin
                    n_state = S_DONE;
                end
            end
            S_RD_LO: begin
                o_cmd.op = vpc_pkg::OP_RD_LO;
                n_state  = (i_status.action == vpc_pkg::ACT_RD_BYTE) ? S_RD_BYTE : S_RD_MID;
            end
            S_RD_MID: begin
                o_cmd.op = vpc_pkg::OP_RD_MID;
                n_state  = S_RD_HI;
            end
            S_RD_HI: begin
                o_cmd.op = vpc_pkg::OP_RD_HI;
                n_state  = S_DONE;
            end
            S_RD_BYTE: begin
                o_cmd.op = vpc_pkg::OP_RD_BYTE;
                n_state  = S_DONE;
            end
            S_CP_RD: begin
                o_cmd.op = vpc_pkg::OP_CP_RD;
                n_state  = S_CP_WR;
            end
            S_CP_WR: begin
                o_cmd.op = vpc_pkg::OP_CP_WR;
                n_state  = i_status.cnt_last ? S_DONE : S_CP_RD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_result_valid = (r_state == S_DONE);

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer did not raise busy");
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe longer than one cycle");
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == vpc_pkg::OP_CLEAR) |-> busy)
        else $error("clear sweep while idle");
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == vpc_pkg::OP_ACCEPT) |-> (start && !busy))
        else $error("accept outside handshake");
`endif

endmodule

// ----- sv/vpc_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpc_dp
// Datapath: byte registers, command latch, access address, DMA counters and
// the three memories, driven one micro-operation per cycle.
// ----------------------------------------------------------------------------
module vpc_dp #(
    parameter int VRAM_BYTES  = vpc_pkg::VRAM_BYTES_DEF,
    parameter int CRAM_BYTES  = vpc_pkg::CRAM_BYTES_DEF,
    parameter int VSRAM_BYTES = vpc_pkg::VSRAM_BYTES_DEF,
    parameter int REG_COUNT   = vpc_pkg::REG_COUNT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vpc_pkg::t_cmd    i_cmd,
    input  logic [1:0]       i_action,
    input  logic [15:0]      i_data_word,
    output vpc_pkg::t_status o_status,
    output logic [15:0]      o_read_data,
    output logic             o_irq_recheck,
    output logic [3:0]       o_dirty_flags
);

    localparam int VA = $clog2(VRAM_BYTES);
    localparam int CA = $clog2(CRAM_BYTES);
    localparam int SA = $clog2(VSRAM_BYTES);

    logic [7:0]  r_regs [REG_COUNT];
    logic [7:0]  n_regs [REG_COUNT];
    logic        r_pending, n_pending;
    logic [15:0] r_first, n_first;
    logic [5:0]  r_mode, n_mode;
    logic [15:0] r_addr, n_addr;
    logic        r_armed, n_armed;
    logic [3:0]  r_dirty, n_dirty;
    logic [1:0]  r_act, n_act;
    logic [15:0] r_word, n_word;
    logic [15:0] r_src, n_src;
    logic [16:0] r_cnt, n_cnt;
    logic [15:0] r_clr, n_clr;
    logic [15:0] r_rd, n_rd;
    logic        r_irq, n_irq;

    logic [7:0]  inc;
    logic [1:0]  kind;
    logic [15:0] len;
    logic [15:0] adv_addr;
    logic [15:0] swapped;
    logic [4:0]  reg_sel;
    logic        copy_arm;
    logic        wr_vram, wr_cram, wr_vsram;
    logic        rd_ok;
    logic [7:0]  rd_byte;
    logic [15:0] raw;
    logic [16:0] raw_v, raw_c, raw_s;
    logic        we_v, we_c, we_s;
    logic [7:0]  wdata;
    logic [7:0]  vram_q, cram_q, vsram_q;

    assign inc      = r_regs[vpc_pkg::REG_AUTOINC];
    assign kind     = r_regs[vpc_pkg::REG_DMA_KIND][7:6];
    assign len      = {r_regs[vpc_pkg::REG_LEN_HI], r_regs[vpc_pkg::REG_LEN_LO]};
    assign adv_addr = r_addr + {8'h00, inc};
    assign swapped  = r_addr[0] ? {r_word[7:0], r_word[15:8]} : r_word;
    assign reg_sel  = r_word[12:8];
    assign copy_arm = r_word[7] && r_regs[vpc_pkg::REG_MODE2][4];

    assign wr_vram  = (r_mode == vpc_pkg::MODE_VRAM_WR);
    assign wr_cram  = (r_mode == vpc_pkg::MODE_CRAM_WR);
    assign wr_vsram = (r_mode == vpc_pkg::MODE_VSRAM_WR);

    always_comb begin
        rd_ok   = 1'b1;
        rd_byte = 8'h00;
        case (r_mode)
            vpc_pkg::MODE_VRAM_RD:  rd_byte = vram_q;
            vpc_pkg::MODE_CRAM_RD:  rd_byte = cram_q;
            vpc_pkg::MODE_VSRAM_RD: rd_byte = vsram_q;
            default:                rd_ok   = 1'b0;
        endcase
    end

    // Memory address and write data per micro-operation
    always_comb begin
        raw   = r_addr;
        we_v  = 1'b0;
        we_c  = 1'b0;
        we_s  = 1'b0;
        wdata = r_word[7:0];
        case (i_cmd.op)
            vpc_pkg::OP_CLEAR: begin
                raw   = r_clr;
                we_v  = 1'b1;
                we_c  = 1'b1;
                we_s  = 1'b1;
                wdata = 8'h00;
            end
            vpc_pkg::OP_WR_LO: begin
                raw   = r_addr & 16'hFFFE;
                we_v  = wr_vram;
                we_c  = wr_cram;
                we_s  = wr_vsram;
                wdata = swapped[7:0];
            end
            vpc_pkg::OP_WR_HI: begin
                raw   = (r_addr & 16'hFFFE) | 16'h0001;
                we_v  = wr_vram;
                we_c  = wr_cram;
                we_s  = wr_vsram;
                wdata = r_word[15:8];
            end
            vpc_pkg::OP_FILL: begin
                we_v = 1'b1;
            end
            vpc_pkg::OP_RD_LO: begin
                raw = (r_act == vpc_pkg::ACT_RD_BYTE) ? (r_addr ^ 16'h0001) : r_addr;
            end
            vpc_pkg::OP_RD_MID: begin
                raw = r_addr + 16'h0001;
            end
            vpc_pkg::OP_CP_RD: begin
                raw = r_src;
            end
            vpc_pkg::OP_CP_WR: begin
                we_v  = 1'b1;
                wdata = vram_q;
            end
            default: begin
                raw = r_addr;
            end
        endcase
    end

    assign raw_v = {1'b0, raw} % 17'(VRAM_BYTES);
    assign raw_c = {1'b0, raw} % 17'(CRAM_BYTES);
    assign raw_s = {1'b0, raw} % 17'(VSRAM_BYTES);

    vpc_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_vram (
        .i_clk(i_clk), .i_we(we_v), .i_addr(raw_v[VA-1:0]), .i_wdata(wdata), .o_rdata(vram_q)
    );
    vpc_ram #(.WIDTH(8), .DEPTH(CRAM_BYTES)) u_cram (
        .i_clk(i_clk), .i_we(we_c), .i_addr(raw_c[CA-1:0]), .i_wdata(wdata), .o_rdata(cram_q)
    );
    vpc_ram #(.WIDTH(8), .DEPTH(VSRAM_BYTES)) u_vsram (
        .i_clk(i_clk), .i_we(we_s), .i_addr(raw_s[SA-1:0]), .i_wdata(wdata), .o_rdata(vsram_q)
    );

    always_comb begin
        n_regs    = r_regs;
        n_pending = r_pending;
        n_first   = r_first;
        n_mode    = r_mode;
        n_addr    = r_addr;
        n_armed   = r_armed;
        n_dirty   = r_dirty;
        n_act     = r_act;
        n_word    = r_word;
        n_src     = r_src;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_rd      = r_rd;
        n_irq     = r_irq;
        case (i_cmd.op)
            vpc_pkg::OP_CLEAR: begin
                n_clr = r_clr + 16'h0001;
            end
            vpc_pkg::OP_ACCEPT: begin
                n_act  = i_action;
                n_word = i_data_word;
                n_rd   = 16'h0000;
                n_irq  = 1'b0;
            end
            vpc_pkg::OP_CTRL: begin
                if (r_pending) begin
                    n_pending = 1'b0;
                    n_armed   = copy_arm;
                    n_mode    = r_word[5:0] & 6'h30 | {2'b00, r_first[15:14], 2'b00};
                    n_addr    = {r_word[1:0], r_first[13:0]};
                    n_src     = {r_regs[vpc_pkg::REG_SRC_HI], r_regs[vpc_pkg::REG_SRC_LO]};
                    n_cnt     = (len == 16'h0000) ? 17'h10000 : {1'b0, len};
                    if (copy_arm && kind == vpc_pkg::DMA_COPY) begin
                        n_dirty[0] = 1'b1;
                    end
                end else if (r_word[15:14] == 2'b10) begin
                    if (32'(reg_sel) < REG_COUNT) begin
                        n_regs[reg_sel] = r_word[7:0];
                        n_dirty[3]      = 1'b1;
                    end
                    n_irq   = (reg_sel == 5'd0) || (reg_sel == 5'd1);
                    n_mode  = 6'h00;
                    n_armed = 1'b0;
                end else begin
                    n_first   = r_word;
                    n_pending = 1'b1;
                end
            end
            vpc_pkg::OP_WR_LO: begin
                n_word = swapped;
                if (wr_vram)  n_dirty[0] = 1'b1;
                if (wr_cram)  n_dirty[1] = 1'b1;
                if (wr_vsram) n_dirty[2] = 1'b1;
            end
            vpc_pkg::OP_WR_HI: begin
                n_addr    = adv_addr;
                n_pending = 1'b0;
                n_armed   = 1'b0;
                n_cnt     = {1'b0, len};
                if (r_armed && kind == vpc_pkg::DMA_FILL) begin
                    n_dirty[0] = 1'b1;
                end
            end
            vpc_pkg::OP_FILL, vpc_pkg::OP_CP_WR: begin
                n_addr = adv_addr;
                n_src  = r_src + 16'h0001;
                n_cnt  = r_cnt - 17'h00001;
            end
            vpc_pkg::OP_RD_MID: begin
                n_rd[7:0] = rd_ok ? rd_byte : 8'h00;
            end
            vpc_pkg::OP_RD_HI: begin
                n_rd[15:8] = rd_ok ? rd_byte : 8'h00;
                n_addr     = adv_addr;
                n_pending  = 1'b0;
            end
            vpc_pkg::OP_RD_BYTE: begin
                n_rd      = {8'h00, rd_ok ? rd_byte : 8'h00};
                n_addr    = adv_addr;
                n_pending = 1'b0;
            end
            default: begin
                n_rd = r_rd;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= 8'h00;
            end
            r_pending <= 1'b0;
            r_first   <= 16'h0000;
            r_mode    <= 6'h00;
            r_addr    <= 16'h0000;
            r_armed   <= 1'b0;
            r_dirty   <= 4'h0;
            r_clr     <= 16'h0000;
            r_irq     <= 1'b0;
            r_cnt     <= 17'h00000;
        end else begin
            r_regs    <= n_regs;
            r_pending <= n_pending;
            r_first   <= n_first;
            r_mode    <= n_mode;
            r_addr    <= n_addr;
            r_armed   <= n_armed;
            r_dirty   <= n_dirty;
            r_clr     <= n_clr;
            r_irq     <= n_irq;
            r_cnt     <= n_cnt;
        end
        r_act  <= n_act;
        r_word <= n_word;
        r_src  <= n_src;
        r_rd   <= n_rd;
    end

    assign o_status.action   = r_act;
    assign o_status.copy_go  = r_pending && copy_arm && (kind == vpc_pkg::DMA_COPY);
    assign o_status.fill_go  = r_armed && (kind == vpc_pkg::DMA_FILL) && (len != 16'h0000);
    assign o_status.cnt_last = (r_cnt == 17'h00001);
    assign o_status.clr_last = (32'(r_clr) == VRAM_BYTES - 1);

    assign o_read_data   = r_rd;
    assign o_irq_recheck = r_irq;
    assign o_dirty_flags = r_dirty;

`ifndef SYNTHESIS
    a_dirty_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_dirty & $past(r_dirty)) == $past(r_dirty)))
        else $error("dirty flag dropped");
    a_fill_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vpc_pkg::OP_FILL) |-> (r_cnt != 17'h00000))
        else $error("fill step with zero count");
    a_copy_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == vpc_pkg::OP_CP_WR) |-> r_dirty[0])
        else $error("copy without vram dirty");
`endif

endmodule
